/* src/rct_pkg.sv */
// Package for the request credit throttle.
// Holds the result, control and state types, command codes and fixed widths.
// No dependencies; rct_ctrl, rct_dp and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package rct_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned MethodW = 2;
  localparam int unsigned TagW    = 16;
  localparam int unsigned CreditW = 8;
  localparam int unsigned EntryW  = MethodW + TagW;

  // Credit count and ceiling after reset.
  localparam logic [CreditW-1:0] ResetCredits = 8'd4;

  // Input command codes.
  localparam logic CmdRequest = 1'b0;
  localparam logic CmdTick    = 1'b1;

  // One result item.
  typedef struct packed {
    logic               issue_valid;
    logic [MethodW-1:0] issue_method;
    logic [TagW-1:0]    issue_tag;
    logic               deferred;
    logic               dropped;
    logic [CreditW-1:0] credits_left;
    logic               timer_running;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;    // Input transfer happens this cycle.
    logic pop_load;  // Queue read data is valid; load it into the result.
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pop_needed;  // The offered item pops the wait queue.
  } dp_status_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

endpackage : rct_pkg

`default_nettype wire

/* src/rct_req_if.sv */
// Input channel of the request credit throttle: valid/ready plus the item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface rct_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [1:0]  method;
  logic [15:0] tag;

  modport source (output valid, cmd, method, tag, input ready);
  modport sink   (input valid, cmd, method, tag, output ready);
endinterface : rct_req_if

`default_nettype wire

/* src/rct_res_if.sv */
// Output channel of the request credit throttle: valid/ready plus the result.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface rct_res_if;
  logic        valid;
  logic        ready;
  logic        issue_valid;
  logic [1:0]  issue_method;
  logic [15:0] issue_tag;
  logic        deferred;
  logic        dropped;
  logic [7:0]  credits_left;
  logic        timer_running;

  modport source (output valid, issue_valid, issue_method, issue_tag, deferred, dropped,
                  credits_left, timer_running, input ready);
  modport sink   (input valid, issue_valid, issue_method, issue_tag, deferred, dropped,
                  credits_left, timer_running, output ready);
endinterface : rct_res_if

`default_nettype wire

/* src/rct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rct_ram #(
  parameter int unsigned Width = 18,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : rct_ram

`default_nettype wire

/* src/rct_ctrl.sv */
// Controller of the request credit throttle: handshakes and result valid.
// Depends on rct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rct_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire rct_pkg::dp_status_t status_i,
  output rct_pkg::ctrl_cmd_t       cmd_o
);
  import rct_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // Take a new item only when idle and the result slot is free or draining.
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // State and result-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cmd_o.accept   = accept;
    cmd_o.pop_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.pop_needed) begin
            // Wait in ST_POP for the registered queue read data.
            state_d     = ST_POP;
            out_valid_d = 1'b0;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_POP: begin
        cmd_o.pop_load = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The result slot is empty while a queue read is in flight.
  a_pop_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> !out_valid_q)
    else $error("result valid during queue read");

  // A queue read always completes into a presented result on the next cycle.
  a_pop_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("queue read did not produce a result");

endmodule : rct_ctrl

`default_nettype wire

/* src/rct_dp.sv */
// Datapath of the request credit throttle: credits, timer, wait queue, result.
// Depends on rct_pkg and rct_ram.
`timescale 1ns / 1ps
`default_nettype none

module rct_dp #(
  parameter int unsigned QueueDepth = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rct_pkg::CreditW-1:0]    cfg_wdata_i,
  input  wire logic                           cmd_i,
  input  wire logic [rct_pkg::MethodW-1:0]    method_i,
  input  wire logic [rct_pkg::TagW-1:0]       tag_i,
  input  wire rct_pkg::ctrl_cmd_t             ctrl_i,
  output rct_pkg::dp_status_t                 status_o,
  output rct_pkg::res_t                       res_o
);
  import rct_pkg::*;

  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  logic [CreditW-1:0] max_q;
  logic [CreditW-1:0] credit_q, credit_d;
  logic [IdxW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               timer_q, timer_d;
  res_t               res_q, res_d;
  logic               push, pop;
  logic [EntryW-1:0]  rdata;
  logic [CreditW-1:0] credit_inc;

  // The offered item pops the queue: a tick while running with requests waiting.
  assign status_o.pop_needed = (cmd_i == CmdTick) && timer_q && (count_q != '0);
  assign res_o               = res_q;
  assign credit_inc          = (credit_q < max_q) ? credit_q + 1'b1 : credit_q;

  // Step logic for one accepted item.
  always_comb begin
    credit_d = credit_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    timer_d  = timer_q;
    push     = 1'b0;
    pop      = 1'b0;
    res_d    = '0;
    if (cmd_i == CmdRequest) begin
      timer_d = 1'b1;
      if (credit_q != '0) begin
        credit_d           = credit_q - 1'b1;
        res_d.issue_valid  = 1'b1;
        res_d.issue_method = method_i;
        res_d.issue_tag    = tag_i;
      end else if (count_q >= FullCnt) begin
        res_d.dropped = 1'b1;
      end else begin
        push           = 1'b1;
        tail_d         = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
        count_d        = count_q + 1'b1;
        res_d.deferred = 1'b1;
      end
    end else if (timer_q) begin
      if (count_q == '0) begin
        credit_d = credit_inc;
        if (credit_inc >= max_q) begin
          timer_d = 1'b0;
        end
      end else begin
        // Issue fields are filled in later from the queue's registered read data.
        pop               = 1'b1;
        head_d            = (head_q == LastIdx) ? '0 : head_q + 1'b1;
        count_d           = count_q - 1'b1;
        res_d.issue_valid = 1'b1;
      end
    end
    res_d.credits_left  = credit_d;
    res_d.timer_running = timer_d;
  end

  // Control state and the credit ceiling.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= ResetCredits;
      credit_q <= ResetCredits;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      timer_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (ctrl_i.accept) begin
        credit_q <= credit_d;
        head_q   <= head_d;
        tail_q   <= tail_d;
        count_q  <= count_d;
        timer_q  <= timer_d;
      end
    end
  end

  // Result register; a pop fills in the issued request from the queue.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      res_q <= res_d;
    end else if (ctrl_i.pop_load) begin
      res_q.issue_method <= rdata[EntryW-1:TagW];
      res_q.issue_tag    <= rdata[TagW-1:0];
    end
  end

  // Wait queue storage.
  rct_ram #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.accept && push),
    .waddr_i (tail_q),
    .wdata_i ({method_i, tag_i}),
    .re_i    (ctrl_i.accept && pop),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("wait queue count overflow");

  // An accepted request with credit on hand spends exactly one credit.
  a_credit_spend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.accept && (cmd_i == CmdRequest) && (credit_q != '0))
      |=> (credit_q == $past(credit_q) - 1'b1))
    else $error("credit not spent on issued request");

endmodule : rct_dp

`default_nettype wire

/* src/request_credit_throttle.sv */
// Top level of the request credit throttle: controller, datapath and channels.
// Depends on rct_pkg, rct_req_if, rct_res_if, rct_ctrl, rct_dp and rct_ram.
//
//   Channel   Dir  Handshake       Payload
//   req_i     in   valid / ready   cmd, method, tag
//   res_o     out  valid / ready   issue_*, deferred, dropped, credits_left, timer_running
//   cfg       in   cfg_we_i        cfg_wdata_i (max_credits)
//
// An item that does not pop the wait queue goes straight to the result register;
// a tick that pops also waits on the registered read port of the queue RAM.
// A finished result is held in an output register; with no queue read pending,
// the next item is taken in the cycle that result transfers out, or once it is empty.
// Reset is asynchronous, active low: credits and ceiling return to 4, queue
// empty, timer stopped. No clearing pass is needed.
// Input ready drops while a result stalls and the output is not taken.
`timescale 1ns / 1ps
`default_nettype none

module request_credit_throttle #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  rct_req_if.sink         req_i,
  rct_res_if.source       res_o
);
  import rct_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;
  res_t       res;

  // Sequencing of transfers.
  rct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  // Credit, timer and queue state.
  rct_dp #(
    .QueueDepth (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (req_i.cmd),
    .method_i    (req_i.method),
    .tag_i       (req_i.tag),
    .ctrl_i      (ctrl_cmd),
    .status_o    (dp_status),
    .res_o       (res)
  );

  // Result payload onto the output channel.
  assign res_o.issue_valid   = res.issue_valid;
  assign res_o.issue_method  = res.issue_method;
  assign res_o.issue_tag     = res.issue_tag;
  assign res_o.deferred      = res.deferred;
  assign res_o.dropped       = res.dropped;
  assign res_o.credits_left  = res.credits_left;
  assign res_o.timer_running = res.timer_running;

endmodule : request_credit_throttle

`default_nettype wire
